// File: hw/rtl/osc_pkg.sv
package osc_pkg;

    localparam int INDEX_WIDTH_DEF   = 24;
    localparam int FRAC_BITS_DEF     = 30;
    localparam int CORDIC_STAGES_DEF = 30;

    localparam int QW     = 61;
    localparam int DW     = 64;
    localparam int TRIG_W = 32;
    localparam int FOLD_STAGES = 4;

    localparam logic [DW-1:0] ONE_Q        = 64'h2000_0000_0000_0000;
    localparam logic [DW-1:0] PI_QUARTER_Q = 64'h1921_FB54_442D_1847;
    localparam logic [DW-1:0] RSQRT2_Q     = 64'h16A0_9E66_7F3B_CC91;

    typedef struct packed {
        logic want_sin;
        logic minus;
    } sel_t;

    function automatic logic [DW-1:0] udiv(input logic [DW-1:0] num,
                                           input logic [DW-1:0] den);
        logic [DW:0]   r;
        logic [DW-1:0] q;
        r = '0;
        q = '0;
        for (int b = DW - 1; b >= 0; b--) begin
            r = {r[DW-1:0], num[b]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [DW-1:0] mulq(input logic [DW-1:0] a,
                                           input logic [DW-1:0] b);
        logic [2*DW-1:0] p;
        p = {{DW{1'b0}}, a} * {{DW{1'b0}}, b};
        return p[QW+DW-1:QW];
    endfunction

    function automatic logic [DW-1:0] rsqrt_factor(input int i);
        logic [DW-1:0] s;
        logic [DW-1:0] t;
        logic          stop;
        s    = ONE_Q;
        t    = ONE_Q;
        stop = 1'b0;
        for (int k = 1; k < 64; k++) begin
            if (!stop) begin
                t = udiv((t >> (2 * i)) * DW'(2 * k - 1), DW'(2 * k));
                if (t == '0) begin
                    stop = 1'b1;
                end else if ((k & 1) != 0) begin
                    s = s - t;
                end else begin
                    s = s + t;
                end
            end
        end
        return s;
    endfunction

    function automatic logic signed [DW-1:0] atan_val(input int i);
        logic signed [DW-1:0] s;
        logic [DW-1:0]        term;
        int                   e;
        s = '0;
        if (i == 0) begin
            s = signed'(PI_QUARTER_Q);
        end else begin
            for (int k = 0; k < 64; k++) begin
                e = i * (2 * k + 1);
                if (e <= QW) begin
                    term = udiv(DW'(64'd1 << (QW - e)), DW'(2 * k + 1));
                    if ((k & 1) != 0) begin
                        s = s - signed'(term);
                    end else begin
                        s = s + signed'(term);
                    end
                end
            end
        end
        return s;
    endfunction

    function automatic logic [DW-1:0] cordic_gain(input int stages);
        logic [DW-1:0] g;
        g = RSQRT2_Q;
        for (int i = 1; i < 64; i++) begin
            if (i < stages && 2 * i < 62) begin
                g = mulq(g, rsqrt_factor(i));
            end
        end
        return g;
    endfunction

endpackage

// File: hw/rtl/osc_div.sv
module osc_div
    import osc_pkg::*;
#(
    parameter int W      = INDEX_WIDTH_DEF,
    parameter int STEPS  = QW,
    parameter int SIDE_W = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic [W-1:0]      n,
    input  logic              in_valid,
    input  logic [W-1:0]      rem_in,
    input  logic [STEPS-1:0]  dvd_in,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [W-1:0]      rem_out,
    output logic [STEPS-1:0]  quo_out,
    output logic [SIDE_W-1:0] side_out
);

    logic              vld_reg  [STEPS];
    logic [W-1:0]      rem_reg  [STEPS];
    logic [STEPS-1:0]  dq_reg   [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];

    genvar k;
    generate
        for (k = 0; k < STEPS; k++) begin : g_step
            logic              v_prev;
            logic [W-1:0]      r_prev;
            logic [STEPS-1:0]  dq_prev;
            logic [SIDE_W-1:0] s_prev;
            logic [W:0]        r_sh;
            logic              ge;
            logic [W-1:0]      rem_next;
            logic [STEPS-1:0]  dq_next;

            if (k == 0) begin : g_first
                assign v_prev  = in_valid;
                assign r_prev  = rem_in;
                assign dq_prev = dvd_in;
                assign s_prev  = side_in;
            end else begin : g_rest
                assign v_prev  = vld_reg[k-1];
                assign r_prev  = rem_reg[k-1];
                assign dq_prev = dq_reg[k-1];
                assign s_prev  = side_reg[k-1];
            end

            always_comb begin
                r_sh     = {r_prev, dq_prev[STEPS-1]};
                ge       = (r_sh >= {1'b0, n});
                rem_next = ge ? W'(r_sh - {1'b0, n}) : r_sh[W-1:0];
                dq_next  = {dq_prev[STEPS-2:0], ge};
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (en) begin
                    vld_reg[k] <= v_prev;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k]  <= rem_next;
                    dq_reg[k]   <= dq_next;
                    side_reg[k] <= s_prev;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[STEPS-1];
    assign rem_out   = rem_reg[STEPS-1];
    assign quo_out   = dq_reg[STEPS-1];
    assign side_out  = side_reg[STEPS-1];

endmodule

// File: hw/rtl/osc_fold.sv
module osc_fold
    import osc_pkg::*;
#(
    parameter int W = INDEX_WIDTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic [W-1:0] n,
    input  logic         in_valid,
    input  logic [W-1:0] a,
    input  logic         neg,
    input  logic         cmd,
    output logic         out_valid,
    output logic [W-1:0] mu,
    output sel_t         sel
);

    localparam int MW = W + 5;

    logic                 vld_reg [FOLD_STAGES];
    logic signed [MW-1:0] m_reg   [FOLD_STAGES];
    sel_t                 sel_reg [FOLD_STAGES];

    logic signed [MW-1:0] nn;
    logic signed [MW-1:0] m_init;
    sel_t                 sel_init;

    always_comb begin
        nn = signed'({5'b0, n});
        m_init = signed'({2'b0, a, 3'b0});
        if (neg) begin
            m_init = -m_init;
        end
        sel_init.want_sin = cmd;
        sel_init.minus    = 1'b0;
    end

    genvar k;
    generate
        for (k = 0; k < FOLD_STAGES; k++) begin : g_fold
            logic                 v_prev;
            logic signed [MW-1:0] m_prev;
            sel_t                 s_prev;
            logic signed [MW-1:0] m_next;
            sel_t                 s_next;

            if (k == 0) begin : g_first
                assign v_prev = in_valid;
                assign m_prev = m_init;
                assign s_prev = sel_init;
            end else begin : g_rest
                assign v_prev = vld_reg[k-1];
                assign m_prev = m_reg[k-1];
                assign s_prev = sel_reg[k-1];
            end

            always_comb begin
                m_next = m_prev;
                s_next = s_prev;
                if (m_next < 0) begin
                    m_next = -m_next;
                    if (s_next.want_sin) begin
                        s_next.minus = !s_next.minus;
                    end
                end
                if (m_next > (nn <<< 2)) begin
                    m_next = (nn <<< 3) - m_next;
                    if (s_next.want_sin) begin
                        s_next.minus = !s_next.minus;
                    end
                end else if (m_next > nn) begin
                    m_next = (nn <<< 1) - m_next;
                    s_next.want_sin = !s_next.want_sin;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (en) begin
                    vld_reg[k] <= v_prev;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    m_reg[k]   <= m_next;
                    sel_reg[k] <= s_next;
                end
            end
        end
    endgenerate

    always_comb begin
        if (m_reg[FOLD_STAGES-1] < 0) begin
            mu = '0;
        end else if (m_reg[FOLD_STAGES-1] > nn) begin
            mu = n;
        end else begin
            mu = m_reg[FOLD_STAGES-1][W-1:0];
        end
    end

    assign out_valid = vld_reg[FOLD_STAGES-1];
    assign sel       = sel_reg[FOLD_STAGES-1];

endmodule

// File: hw/rtl/osc_cordic.sv
module osc_cordic
    import osc_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [QW:0]          q,
    input  sel_t                 sel_in,
    output logic                 out_valid,
    output logic signed [DW-1:0] r_out,
    output sel_t                 sel_out
);

    localparam logic [DW-1:0] GAIN = cordic_gain(CORDIC_STAGES);
    localparam logic [31:0]   C0   = PI_QUARTER_Q[31:0];
    localparam logic [31:0]   C1   = PI_QUARTER_Q[63:32];

    // angle = q * pi/4, split into 32x32 partial products
    logic        m1_vld_reg, m2_vld_reg, m3_vld_reg;
    sel_t        m1_sel_reg, m2_sel_reg, m3_sel_reg;
    logic [63:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic [63:0] m2_p00_reg, m2_p11_reg;
    logic [64:0] cross_reg;
    logic [DW-1:0] theta_reg;

    logic [31:0]  q0, q1;
    logic [127:0] prod_next;

    always_comb begin
        q0 = q[31:0];
        q1 = 32'(q[QW:32]);
        prod_next = {m2_p11_reg, m2_p00_reg} + {31'b0, cross_reg, 32'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_vld_reg <= 1'b0;
            m2_vld_reg <= 1'b0;
            m3_vld_reg <= 1'b0;
        end else if (en) begin
            m1_vld_reg <= in_valid;
            m2_vld_reg <= m1_vld_reg;
            m3_vld_reg <= m2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p00_reg    <= q0 * C0;
            p01_reg    <= q0 * C1;
            p10_reg    <= q1 * C0;
            p11_reg    <= q1 * C1;
            m1_sel_reg <= sel_in;
            cross_reg  <= {1'b0, p01_reg} + {1'b0, p10_reg};
            m2_p00_reg <= p00_reg;
            m2_p11_reg <= p11_reg;
            m2_sel_reg <= m1_sel_reg;
            theta_reg  <= prod_next[QW+DW-1:QW];
            m3_sel_reg <= m2_sel_reg;
        end
    end

    logic                 vld_reg [CORDIC_STAGES];
    logic signed [DW-1:0] x_reg   [CORDIC_STAGES];
    logic signed [DW-1:0] y_reg   [CORDIC_STAGES];
    logic signed [DW-1:0] z_reg   [CORDIC_STAGES];
    sel_t                 sel_reg [CORDIC_STAGES];

    genvar i;
    generate
        for (i = 0; i < CORDIC_STAGES; i++) begin : g_rot
            localparam logic signed [DW-1:0] ATAN = atan_val(i);
            logic                 v_prev;
            logic signed [DW-1:0] x_prev, y_prev, z_prev;
            sel_t                 s_prev;
            logic signed [DW-1:0] x_next, y_next, z_next;
            logic signed [DW-1:0] dx, dy;

            if (i == 0) begin : g_first
                assign v_prev = m3_vld_reg;
                assign x_prev = signed'(GAIN);
                assign y_prev = '0;
                assign z_prev = signed'(theta_reg);
                assign s_prev = m3_sel_reg;
            end else begin : g_rest
                assign v_prev = vld_reg[i-1];
                assign x_prev = x_reg[i-1];
                assign y_prev = y_reg[i-1];
                assign z_prev = z_reg[i-1];
                assign s_prev = sel_reg[i-1];
            end

            always_comb begin
                dx = y_prev >>> i;
                dy = x_prev >>> i;
                if (z_prev >= 0) begin
                    x_next = x_prev - dx;
                    y_next = y_prev + dy;
                    z_next = z_prev - ATAN;
                end else begin
                    x_next = x_prev + dx;
                    y_next = y_prev - dy;
                    z_next = z_prev + ATAN;
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[i] <= 1'b0;
                end else if (en) begin
                    vld_reg[i] <= v_prev;
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    x_reg[i]   <= x_next;
                    y_reg[i]   <= y_next;
                    z_reg[i]   <= z_next;
                    sel_reg[i] <= s_prev;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[CORDIC_STAGES-1];
    assign sel_out   = sel_reg[CORDIC_STAGES-1];
    assign r_out     = sel_reg[CORDIC_STAGES-1].want_sin ? y_reg[CORDIC_STAGES-1]
                                                         : x_reg[CORDIC_STAGES-1];

endmodule

// File: hw/rtl/octant_reduced_sincos.sv
// Twiddle factor source: cos or sin of 2*pi*m/period in signed Q1.30.
//
// Requests enter on the s_ channel: s_tdata carries the signed index m,
// s_tuser selects cosine (0) or sine (1). Results leave on the m_ channel,
// one per request, in request order. The period is written through
// cfg_we/cfg_wdata by the user only while no request is in flight, which
// the block does not enforce; zero acts as one.
//
// One request per cycle unless m_tready stalls; the pipeline is mostly the
// bit-per-stage modulo and 61-bit fraction dividers and the CORDIC rotator.
//
// Reset empties the pipeline and sets the period to 1. When the receiver
// holds m_tready low with a result waiting, the whole pipeline freezes
// and s_tready drops; nothing is lost or repeated, and bubbles in flight
// keep moving toward the output while the output register is empty.
module octant_reduced_sincos
    import osc_pkg::*;
#(
    parameter int INDEX_WIDTH   = INDEX_WIDTH_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    localparam int AW  = INDEX_WIDTH + 1,
    localparam int TDW = ((AW + 7) / 8) * 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [INDEX_WIDTH-1:0] cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDW-1:0]         s_tdata,   // m_index
    input  logic                   s_tuser,   // cmd
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TRIG_W-1:0]      m_tdata    // trig_value
);

    localparam int SH = QW - FRAC_BITS;
    localparam logic [DW-1:0] SAT = DW'(64'd1 << FRAC_BITS);

    logic [INDEX_WIDTH-1:0] period_reg;
    logic                   en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= INDEX_WIDTH'(1);
        end else if (cfg_we) begin
            period_reg <= (cfg_wdata == '0) ? INDEX_WIDTH'(1) : cfg_wdata;
        end
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // magnitude of the index
    logic          in_vld_reg;
    logic [AW-1:0] a_reg;
    logic          neg_reg, cmd_reg;
    logic [AW-1:0] raw;

    assign raw = s_tdata[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg_reg <= raw[AW-1];
            a_reg   <= raw[AW-1] ? AW'(-raw) : raw;
            cmd_reg <= s_tuser;
        end
    end

    // |m| mod n
    logic                   d1_vld;
    logic [INDEX_WIDTH-1:0] d1_rem;
    logic [AW-1:0]          d1_quo;
    logic [1:0]             d1_side;

    osc_div #(
        .W      (INDEX_WIDTH),
        .STEPS  (AW),
        .SIDE_W (2)
    ) u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .n         (period_reg),
        .in_valid  (in_vld_reg),
        .rem_in    ('0),
        .dvd_in    (a_reg),
        .side_in   ({cmd_reg, neg_reg}),
        .out_valid (d1_vld),
        .rem_out   (d1_rem),
        .quo_out   (d1_quo),
        .side_out  (d1_side)
    );

    logic                   f_vld;
    logic [INDEX_WIDTH-1:0] f_mu;
    sel_t                   f_sel;

    osc_fold #(
        .W (INDEX_WIDTH)
    ) u_fold (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .n         (period_reg),
        .in_valid  (d1_vld),
        .a         (d1_rem),
        .neg       (d1_side[0]),
        .cmd       (d1_side[1]),
        .out_valid (f_vld),
        .mu        (f_mu),
        .sel       (f_sel)
    );

    // fraction mu/n in Q61
    logic                   mu_full;
    logic                   d2_vld;
    logic [INDEX_WIDTH-1:0] d2_rem;
    logic [QW-1:0]          d2_quo;
    logic [$bits(sel_t):0]  d2_side;
    sel_t                   d2_sel;

    assign mu_full = (f_mu == period_reg);
    assign d2_sel  = d2_side[$bits(sel_t)-1:0];

    osc_div #(
        .W      (INDEX_WIDTH),
        .STEPS  (QW),
        .SIDE_W ($bits(sel_t) + 1)
    ) u_frac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .n         (period_reg),
        .in_valid  (f_vld),
        .rem_in    (mu_full ? '0 : f_mu),
        .dvd_in    ('0),
        .side_in   ({mu_full, f_sel}),
        .out_valid (d2_vld),
        .rem_out   (d2_rem),
        .quo_out   (d2_quo),
        .side_out  (d2_side)
    );

    logic                 c_vld;
    logic signed [DW-1:0] c_r;
    sel_t                 c_sel;

    osc_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d2_vld),
        .q         ({d2_side[$bits(sel_t)], d2_quo}),
        .sel_in    (d2_sel),
        .out_valid (c_vld),
        .r_out     (c_r),
        .sel_out   (c_sel)
    );

    // clamp and round
    logic          rnd_vld_reg;
    logic          rnd_minus_reg;
    logic [DW-1:0] mag_reg;
    logic [DW-1:0] clamp;
    logic [DW-1:0] mag_next;

    always_comb begin
        if (c_r < 0) begin
            clamp = '0;
        end else if (unsigned'(c_r) > ONE_Q) begin
            clamp = ONE_Q;
        end else begin
            clamp = unsigned'(c_r);
        end
    end

    generate
        if (SH > 0) begin : g_rnd
            localparam logic [DW-1:0] HALF = DW'(64'd1 << (SH - 1));
            assign mag_next = (clamp + HALF) >> SH;
        end else if (SH < 0) begin : g_up
            assign mag_next = clamp << (-SH);
        end else begin : g_keep
            assign mag_next = clamp;
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rnd_vld_reg <= 1'b0;
        end else if (en) begin
            rnd_vld_reg <= c_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg       <= mag_next;
            rnd_minus_reg <= c_sel.minus;
        end
    end

    // saturate, sign, output register
    logic              m_tvalid_reg;
    logic [TRIG_W-1:0] m_tdata_reg;
    logic [DW-1:0]     sat;
    logic [DW-1:0]     signed_val;

    always_comb begin
        sat        = (mag_reg > SAT) ? SAT : mag_reg;
        signed_val = rnd_minus_reg ? (DW'(0) - sat) : sat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= rnd_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= signed_val[TRIG_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
